// ----- src/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, status codes and the alphabet lookup for the strict base64
// decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCHAR = 3'd1;
  localparam logic [2:0] ST_BADPAD  = 3'd2;
  localparam logic [2:0] ST_LENGTH  = 3'd3;
  localparam logic [2:0] ST_CAPACITY = 3'd4;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [15:0] MAX_BYTES_RESET = 16'd3072;

  typedef struct packed {
    logic [1:0]  quad;
    logic [17:0] store;
    logic [1:0]  pad;
    logic [15:0] produced;
    logic        failed;
  } bsd_state_t;

  typedef struct packed {
    logic        emit;
    logic        byte_valid;
    logic [2:0]  status;
    logic [23:0] word;
    logic [1:0]  last_k;
    logic [15:0] count;
    logic        fin;
  } bsd_res_t;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'd65;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'd71;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
      return {1'b0, t[5:0]};
    end else if (c == CH_PLUS) begin
      return 7'd62;
    end else if (c == CH_SLASH) begin
      return 7'd63;
    end
    return 7'd64;
  endfunction

endpackage

// ----- src/base64_strict_decoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_strict_decoder_core
// Strict streaming base64 decoder, one character word in, decoded byte words
// out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one ASCII character and a flag on the final
//   character of a string. The output channel carries one word per decoded
//   byte, or one closing word with a status when a string fails or is short.
//   cfg_we/cfg_wdata set the per-string byte limit; write only when idle.
// Path:
//   A character is held in the input register; its results are loaded into
//   the output register, which drives the output channel, once that
//   register is free (see Stall).
// Throughput:
//   One character per cycle unless stalled (see Stall). A completed quad
//   holds the output register until each of its bytes (up to three) is
//   taken; characters that give no result keep flowing meanwhile.
// Reset:
//   Clears all string state and the byte limit returns to 3072.
// Stall:
//   While out_ready is low the result word holds; a character that would
//   produce results waits in the input register and in_ready drops.
// ----------------------------------------------------------------------------
module base64_strict_decoder_core
  import bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_final_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_byte_valid,
  output logic        out_run_end,
  output logic        out_string_end,
  output logic [2:0]  out_status,
  output logic [15:0] out_decoded_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] max_r;
  logic        in_vld_r;
  logic [7:0]  in_char_r;
  logic        in_fin_r;
  bsd_state_t  st_r, st_nxt;
  bsd_res_t    res;

  logic        grp_vld_r;
  logic        grp_bv_r;
  logic [2:0]  grp_status_r;
  logic [23:0] grp_word_r;
  logic [1:0]  grp_last_r;
  logic [1:0]  grp_k_r;
  logic [15:0] grp_cnt_r;
  logic        grp_fin_r;

  logic grp_last;
  logic out_fire;
  logic grp_free;
  logic proc_fire;

  bsd_step u_step (
    .cur        (st_r),
    .char_code  (in_char_r),
    .final_char (in_fin_r),
    .max_bytes  (max_r),
    .nxt        (st_nxt),
    .res        (res)
  );

  assign grp_last  = (grp_k_r == grp_last_r);
  assign out_fire  = grp_vld_r && out_ready;
  assign grp_free  = !grp_vld_r || (out_ready && grp_last);
  assign proc_fire = in_vld_r && (!res.emit || grp_free);
  assign in_ready  = !in_vld_r || proc_fire;

  always_comb begin
    case (grp_k_r)
      2'd0:    out_data_byte = grp_word_r[23:16];
      2'd1:    out_data_byte = grp_word_r[15:8];
      default: out_data_byte = grp_word_r[7:0];
    endcase
  end

  assign out_valid         = grp_vld_r;
  assign out_byte_valid    = grp_bv_r;
  assign out_run_end       = grp_last;
  assign out_string_end    = grp_last && grp_fin_r;
  assign out_status        = grp_status_r;
  assign out_decoded_count = grp_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= MAX_BYTES_RESET;
      in_vld_r  <= 1'b0;
      st_r      <= '0;
      grp_vld_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (in_ready) in_vld_r <= in_valid;
      if (proc_fire) st_r <= st_nxt;
      if (proc_fire && res.emit) begin
        grp_vld_r <= 1'b1;
      end else if (out_fire && grp_last) begin
        grp_vld_r <= 1'b0;
      end
    end
  end

  // payload: capture the input character, and load a new group or advance through the current one
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_char_r <= in_char_code;
      in_fin_r  <= in_final_char;
    end
    if (proc_fire && res.emit) begin
      grp_bv_r     <= res.byte_valid;
      grp_status_r <= res.status;
      grp_word_r   <= res.word;
      grp_last_r   <= res.last_k;
      grp_k_r      <= 2'd0;
      grp_cnt_r    <= res.count;
      grp_fin_r    <= res.fin;
    end else if (out_fire && !grp_last) begin
      grp_k_r   <= grp_k_r + 2'd1;
      grp_cnt_r <= grp_cnt_r + 16'd1;
    end
  end

endmodule

// ----- src/bsd_step.sv -----
// ----------------------------------------------------------------------------
// bsd_step
// Next-state and result logic for one character of the strict base64
// decoder.
// ----------------------------------------------------------------------------
module bsd_step
  import bsd_pkg::*;
(
  input  bsd_state_t  cur,
  input  logic [7:0]  char_code,
  input  logic        final_char,
  input  logic [15:0] max_bytes,
  output bsd_state_t  nxt,
  output bsd_res_t    res
);

  logic [6:0]  sx;
  logic [5:0]  v;
  logic [2:0]  code;
  logic [1:0]  p;
  logic [1:0]  p_inc;
  logic [1:0]  pad_n;
  logic [1:0]  n;
  logic [16:0] sum;
  bsd_state_t  cleared;

  assign sx      = sextet_of(char_code);
  assign p       = cur.quad;
  assign p_inc   = p + 2'd1;
  assign cleared = '0;

  always_comb begin
    nxt   = cur;
    res   = '0;
    code  = ST_OK;
    v     = 6'd0;
    pad_n = cur.pad;
    n     = 2'd0;
    sum   = 17'd0;
    if (cur.failed) begin
      nxt.quad = p_inc;
      if (final_char) begin
        res.emit   = 1'b1;
        res.status = (p != 2'd3) ? ST_LENGTH : cur.store[2:0];
        res.count  = cur.produced;
        res.fin    = 1'b1;
        nxt        = cleared;
      end
    end else begin
      if (char_code == CH_PAD) begin
        if (p < 2'd2) code = ST_BADPAD;
        else pad_n = cur.pad + 2'd1;
      end else if (cur.pad != 2'd0) begin
        code = ST_BADPAD;
      end else if (sx[6]) begin
        code = ST_BADCHAR;
      end else begin
        v = sx[5:0];
      end
      if (code == ST_OK && p == 2'd3 && pad_n != 2'd0 && !final_char) code = ST_BADPAD;
      nxt.pad = pad_n;

      if (code == ST_OK && p != 2'd3) begin
        nxt.store = {cur.store[11:0], v};
        nxt.quad  = p_inc;
        if (final_char) begin
          res.emit   = 1'b1;
          res.status = ST_LENGTH;
          res.count  = cur.produced;
          res.fin    = 1'b1;
          nxt        = cleared;
        end
      end else begin
        n   = 2'd3 - pad_n;
        sum = {1'b0, cur.produced} + {15'd0, n};
        if (code == ST_OK && pad_n == 2'd3) code = ST_BADPAD;
        else if (code == ST_OK && sum > {1'b0, max_bytes}) code = ST_CAPACITY;

        if (code != ST_OK) begin
          if (final_char) begin
            res.emit   = 1'b1;
            res.status = (p != 2'd3) ? ST_LENGTH : code;
            res.count  = cur.produced;
            res.fin    = 1'b1;
            nxt        = cleared;
          end else begin
            nxt.failed = 1'b1;
            nxt.store  = {15'd0, code};
            nxt.quad   = p_inc;
          end
        end else begin
          res.emit       = 1'b1;
          res.byte_valid = 1'b1;
          res.status     = ST_OK;
          res.word       = {cur.store, v};
          res.last_k     = n - 2'd1;
          res.count      = cur.produced + 16'd1;
          res.fin        = final_char;
          nxt.quad       = 2'd0;
          nxt.store      = 18'd0;
          nxt.pad        = 2'd0;
          nxt.produced   = sum[15:0];
          if (final_char) nxt = cleared;
        end
      end
    end
  end

endmodule
